// ===== design/kqt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, status codes and structs for the keyed quantity table.
// No dependencies; used by kqt_cell and keyed_quantity_table_top.
package kqt_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam int KEY_IN_W   = 32;
    localparam int CNT_W      = 8;
    localparam int AMT_W      = 9;
    localparam int SUM_W      = AMT_W + 1;
    localparam int SLOT_W     = 4;
    localparam int USED_OUT_W = 5;
    localparam int ST_W       = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_ENTRY_FULL = 3'd1;
    localparam logic [ST_W-1:0] ST_OVER_CAP   = 3'd2;
    localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY      = 3'd4;
    localparam logic [ST_W-1:0] ST_UNKNOWN    = 3'd5;

    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 1'b1;

    localparam logic [CNT_W-1:0] MAX_COUNT_RST     = 8'd10;
    localparam logic [CNT_W-1:0] LOW_THRESHOLD_RST = 8'd2;

    localparam logic [AMT_W-1:0] AMT_MINUS_ONE = 9'h1FF;

    typedef struct packed {
        logic              sel;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              low;
    } kqt_chain_t;

    typedef struct packed {
        logic             valid;
        logic             append;
        logic [CNT_W-1:0] count;
    } kqt_wr_t;

endpackage

// ===== design/kqt_cell.sv =====
`timescale 1ns / 1ps
// One table slot: key and count registers, lookup compare and chain merge.
// Depends on kqt_pkg.
module kqt_cell #(
    parameter int IDX   = 0,
    parameter int KEY_W = 32,
    parameter int UW    = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      lookup_en,
    input  logic                      cmd,
    input  logic [KEY_W-1:0]          key,
    input  logic [kqt_pkg::SLOT_W-1:0] sidx,
    input  logic [UW-1:0]             used,
    input  logic [kqt_pkg::CNT_W-1:0] threshold,
    input  kqt_pkg::kqt_wr_t          wr,
    input  kqt_pkg::kqt_chain_t       chain_in,
    output kqt_pkg::kqt_chain_t       chain_out
);

    localparam int CMP_W = (UW > kqt_pkg::SLOT_W) ? UW : kqt_pkg::SLOT_W;

    logic [KEY_W-1:0]          key_reg;
    logic [kqt_pkg::CNT_W-1:0] cnt_reg;
    logic                      tgt_reg;
    logic                      in_use;
    logic                      target;
    logic                      sel;
    logic                      wr_en;

    assign in_use = UW'(IDX) < used;

    always_comb
    begin
        if (cmd == kqt_pkg::CMD_STORE)
        begin
            target = in_use && (key_reg == key);
        end
        else
        begin
            target = CMP_W'(sidx) == CMP_W'(IDX);
        end
    end

    assign sel = target && in_use;

    always_comb
    begin
        chain_out.sel   = chain_in.sel | sel;
        chain_out.slot  = sel ? kqt_pkg::SLOT_W'(IDX) : chain_in.slot;
        chain_out.count = sel ? cnt_reg : chain_in.count;
        chain_out.low   = chain_in.low | (in_use && !target && (cnt_reg < threshold));
    end

    assign wr_en = wr.valid && (wr.append ? (UW'(IDX) == used) : tgt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg <= 1'b0;
        end
        else if (lookup_en)
        begin
            tgt_reg <= sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_reg <= wr.count;
            if (wr.append)
            begin
                key_reg <= key;
            end
        end
    end

endmodule

// ===== design/keyed_quantity_table_top.sv =====
`timescale 1ns / 1ps
// Keyed quantity table: a chain of slot cells with a lookup and an update step.
// Depends on kqt_pkg and kqt_cell.
// A transaction is registered on acceptance, looked up in S_LOOK, then updated in S_UPD,
// which waits for a free output and registers the result. The update of one item and the
// capture of the next share a cycle, and the lookup reads the cell registers.
// Reset clears the slot count and the control state and sets the two config registers to 10 and 2.
module keyed_quantity_table_top #(
    parameter int ENTRIES  = kqt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = kqt_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [kqt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kqt_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [kqt_pkg::KEY_IN_W-1:0]  item_key,
    input  logic signed [kqt_pkg::AMT_W-1:0] amount,
    input  logic [kqt_pkg::SLOT_W-1:0]    slot_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kqt_pkg::ST_W-1:0]      status,
    output logic [kqt_pkg::SLOT_W-1:0]    slot_used,
    output logic [kqt_pkg::CNT_W-1:0]     slot_count,
    output logic                          slot_empty,
    output logic                          slot_full,
    output logic [kqt_pkg::USED_OUT_W-1:0] used_slots,
    output logic                          low_stock
);

    localparam int KEY_W = (KEY_BITS < kqt_pkg::KEY_IN_W) ? KEY_BITS : kqt_pkg::KEY_IN_W;
    localparam int UW    = $clog2(ENTRIES + 1);
    localparam int CW    = kqt_pkg::CNT_W;
    localparam int SW    = kqt_pkg::SUM_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [CW-1:0] max_count_reg;
    logic [CW-1:0] low_threshold_reg;
    logic [UW-1:0] used_reg;
    logic [UW-1:0] used_next;

    logic                              cmd_reg;
    logic [KEY_W-1:0]                  key_reg;
    logic signed [kqt_pkg::AMT_W-1:0]  amount_reg;
    logic [kqt_pkg::SLOT_W-1:0]        sidx_reg;

    kqt_pkg::kqt_chain_t chain [ENTRIES+1];
    kqt_pkg::kqt_chain_t look_reg;
    kqt_pkg::kqt_wr_t    wr;

    logic out_valid_reg;
    logic [kqt_pkg::ST_W-1:0]       status_reg;
    logic [kqt_pkg::SLOT_W-1:0]     slot_reg;
    logic [CW-1:0]                  count_reg;
    logic                           empty_reg;
    logic                           full_reg;
    logic [kqt_pkg::USED_OUT_W-1:0] used_out_reg;
    logic                           low_reg;

    logic out_free;
    logic fire;
    logic accept;

    logic [kqt_pkg::ST_W-1:0]   st;
    logic [kqt_pkg::SLOT_W-1:0] slot;
    logic [CW-1:0]              cnt;
    logic                       has_slot;

    logic signed [SW-1:0] amt_ext;
    logic signed [SW-1:0] cnt_ext;
    logic signed [SW-1:0] max_ext;
    logic signed [SW-1:0] sum;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = (state_reg == S_UPD) && out_free;
    assign in_ready = (state_reg == S_IDLE) || fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_LOOK;
            S_LOOK: state_next = S_UPD;
            S_UPD:  if (fire) state_next = accept ? S_LOOK : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            max_count_reg     <= kqt_pkg::MAX_COUNT_RST;
            low_threshold_reg <= kqt_pkg::LOW_THRESHOLD_RST;
            used_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kqt_pkg::REG_MAX_COUNT:     max_count_reg     <= cfg_data;
                    kqt_pkg::REG_LOW_THRESHOLD: low_threshold_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (fire)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            key_reg    <= item_key[KEY_W-1:0];
            amount_reg <= amount;
            sidx_reg   <= slot_index;
        end
        if (state_reg == S_LOOK)
        begin
            look_reg <= chain[ENTRIES];
        end
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kqt_cell #(
            .IDX   (i),
            .KEY_W (KEY_W),
            .UW    (UW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .lookup_en (state_reg == S_LOOK),
            .cmd       (cmd_reg),
            .key       (key_reg),
            .sidx      (sidx_reg),
            .used      (used_reg),
            .threshold (low_threshold_reg),
            .wr        (wr),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    assign amt_ext = {amount_reg[kqt_pkg::AMT_W-1], amount_reg};
    assign cnt_ext = {2'b00, look_reg.count};
    assign max_ext = {2'b00, max_count_reg};
    assign sum     = cnt_ext + amt_ext;

    always_comb
    begin
        st        = kqt_pkg::ST_OK;
        slot      = '0;
        cnt       = '0;
        has_slot  = 1'b0;
        used_next = used_reg;
        wr.valid  = 1'b0;
        wr.append = 1'b0;
        wr.count  = '0;
        if (cmd_reg == kqt_pkg::CMD_STORE)
        begin
            if (look_reg.sel)
            begin
                slot     = look_reg.slot;
                has_slot = 1'b1;
                cnt      = look_reg.count;
                if ((look_reg.count >= max_count_reg) && (amount_reg != kqt_pkg::AMT_MINUS_ONE))
                begin
                    st = kqt_pkg::ST_ENTRY_FULL;
                end
                else if (sum > max_ext)
                begin
                    st = kqt_pkg::ST_OVER_CAP;
                end
                else if (sum < 0)
                begin
                    st = kqt_pkg::ST_EMPTY;
                end
                else
                begin
                    cnt      = sum[CW-1:0];
                    wr.valid = fire;
                    wr.count = sum[CW-1:0];
                end
            end
            else if (used_reg >= UW'(ENTRIES))
            begin
                st = kqt_pkg::ST_TABLE_FULL;
            end
            else if (amt_ext > max_ext)
            begin
                st = kqt_pkg::ST_OVER_CAP;
            end
            else if (amt_ext < 0)
            begin
                st = kqt_pkg::ST_EMPTY;
            end
            else
            begin
                slot      = kqt_pkg::SLOT_W'(used_reg);
                cnt       = amount_reg[CW-1:0];
                has_slot  = 1'b1;
                used_next = used_reg + 1'b1;
                wr.valid  = fire;
                wr.append = 1'b1;
                wr.count  = amount_reg[CW-1:0];
            end
        end
        else
        begin
            slot = sidx_reg;
            if (!look_reg.sel)
            begin
                st = kqt_pkg::ST_UNKNOWN;
            end
            else
            begin
                has_slot = 1'b1;
                if (look_reg.count == '0)
                begin
                    st = kqt_pkg::ST_EMPTY;
                end
                else
                begin
                    cnt      = look_reg.count - 1'b1;
                    wr.valid = fire;
                    wr.count = look_reg.count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= st;
            slot_reg     <= slot;
            count_reg    <= cnt;
            empty_reg    <= has_slot && (cnt == '0);
            full_reg     <= has_slot && (cnt >= max_count_reg);
            used_out_reg <= kqt_pkg::USED_OUT_W'(used_next);
            low_reg      <= look_reg.low || (has_slot && (cnt < low_threshold_reg));
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_used  = slot_reg;
    assign slot_count = count_reg;
    assign slot_empty = empty_reg;
    assign slot_full  = full_reg;
    assign used_slots = used_out_reg;
    assign low_stock  = low_reg;

endmodule
